/* design/rtphp_pkg.sv */
`timescale 1ns / 1ps

package rtphp_pkg;

    // Field widths of one result transaction
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PTYPE_W  = 7;
    localparam int unsigned SEQ_W    = 16;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CC_W     = 4;
    localparam int unsigned LEN_W    = 11;
    localparam int unsigned STATUS_W = 3;

    // Skip counter holds up to 4 * 65535 extension bytes
    localparam int unsigned SKIP_W   = 18;
    localparam int unsigned EXTLEN_W = 16;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Packet status codes; priority after ok: short, too long, version, csrc, extension, padding
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_VERSION   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CSRC      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXTENSION = 3'd4;
    localparam logic [STATUS_W-1:0] ST_PADDING   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd6;

    // Only RTP version 2 is parsed
    localparam logic [1:0] RTP_VERSION = 2'd2;

    // Fixed header length in bytes
    localparam int unsigned FIXED_HDR_BYTES = 12;

    // Longest payload length that the output field can carry
    localparam int unsigned LEN_MAX = 2047;

    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic                marker_bit;
        logic [PTYPE_W-1:0]  payload_kind;
        logic [SEQ_W-1:0]    sequence_number;
        logic [WORD_W-1:0]   media_timestamp;
        logic [WORD_W-1:0]   source_id;
        logic [CC_W-1:0]     contributor_count;
        logic [BYTE_W-1:0]   pad_count;
        logic [LEN_W-1:0]    payload_length;
        logic [STATUS_W-1:0] parse_status;
        logic                last_result;
    } result_t;

    // Up to two results produced by one input byte, first one first
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

/* design/rtp_header_parser.sv */
`timescale 1ns / 1ps

// RTP header parser. Takes one packet byte per cycle while s_ready is high,
// with s_end_of_packet on the final byte, decodes the 12-byte fixed header,
// skips CSRC words and any header extension, and passes each later byte out
// as a candidate payload transaction. The final byte also yields a summary
// transaction carrying the header fields, pad count, payload length after
// padding removal and a status; downstream trims padding by the length and
// drops the payload on a nonzero status. Each byte is parsed in the cycle it
// is accepted and its results are registered into the result queue, whose
// head drives the m_ side. A final byte that is itself payload produces two
// transactions, which leave the four-entry result queue one at a time, so a
// packet with P payload bytes yields P + 1 transactions. s_ready drops when
// the queue holds three or more.
module rtp_header_parser #(
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_data_byte,
    input  logic         s_end_of_packet,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_result_kind,
    output logic [7:0]   m_payload_byte,
    output logic         m_marker_bit,
    output logic [6:0]   m_payload_kind,
    output logic [15:0]  m_sequence_number,
    output logic [31:0]  m_media_timestamp,
    output logic [31:0]  m_source_id,
    output logic [3:0]   m_contributor_count,
    output logic [7:0]   m_pad_count,
    output logic [10:0]  m_payload_length,
    output logic [2:0]   m_parse_status,
    output logic         m_last_result
);

    rtphp_pkg::push_t   push;
    rtphp_pkg::result_t head;
    logic               in_accept;
    logic               has_room;
    logic               not_empty;

    assign s_ready   = has_room;
    assign in_accept = s_valid && has_room;
    assign m_valid   = not_empty;

    rtphp_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_accept     (in_accept),
        .data_byte     (s_data_byte),
        .end_of_packet (s_end_of_packet),
        .push          (push)
    );

    rtphp_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (not_empty && m_ready),
        .has_room  (has_room),
        .not_empty (not_empty),
        .head      (head)
    );

    // Drive the result transaction from the queue head
    assign m_result_kind       = head.kind;
    assign m_payload_byte      = head.payload_byte;
    assign m_marker_bit        = head.marker_bit;
    assign m_payload_kind      = head.payload_kind;
    assign m_sequence_number   = head.sequence_number;
    assign m_media_timestamp   = head.media_timestamp;
    assign m_source_id         = head.source_id;
    assign m_contributor_count = head.contributor_count;
    assign m_pad_count         = head.pad_count;
    assign m_payload_length    = head.payload_length;
    assign m_parse_status      = head.parse_status;
    assign m_last_result       = head.last_result;

endmodule

/* design/rtphp_parser.sv */
`timescale 1ns / 1ps

module rtphp_parser #(
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_accept,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_packet,
    output rtphp_pkg::push_t      push
);

    localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 2);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PACKET_BYTES);

    // Parse phases
    localparam logic [2:0] PH_FIXED   = 3'd0;
    localparam logic [2:0] PH_CSRC    = 3'd1;
    localparam logic [2:0] PH_EXTHDR  = 3'd2;
    localparam logic [2:0] PH_EXTBODY = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_DISCARD = 3'd5;

    logic [2:0]                          phase_reg, phase_next;
    logic [POS_W-1:0]                    pos_reg, pos_next;
    logic [rtphp_pkg::SKIP_W-1:0]        skip_reg, skip_next;
    logic [1:0]                          version_reg, version_next;
    logic                                padding_reg, padding_next;
    logic                                ext_reg, ext_next;
    logic [rtphp_pkg::CC_W-1:0]          csrc_reg, csrc_next;
    logic                                marker_reg, marker_next;
    logic [rtphp_pkg::PTYPE_W-1:0]       type_reg, type_next;
    logic [rtphp_pkg::SEQ_W-1:0]         seq_reg, seq_next;
    logic [rtphp_pkg::WORD_W-1:0]        ts_reg, ts_next;
    logic [rtphp_pkg::WORD_W-1:0]        src_reg, src_next;
    logic [rtphp_pkg::EXTLEN_W-1:0]      extlen_reg, extlen_next;
    logic [POS_W-1:0]                    cnt_reg, cnt_next;

    logic                                emit_payload;
    logic [rtphp_pkg::SKIP_W-1:0]        skip_dec;
    logic [rtphp_pkg::STATUS_W-1:0]      status;
    logic [7:0]                          pad;
    logic [POS_W-1:0]                    kept;
    rtphp_pkg::result_t                  pay_res;
    rtphp_pkg::result_t                  sum_res;

    assign skip_dec = (skip_reg != '0) ? skip_reg - 1'b1 : skip_reg;

    // Advance the parse state by one packet byte
    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        skip_next    = skip_reg;
        version_next = version_reg;
        padding_next = padding_reg;
        ext_next     = ext_reg;
        csrc_next    = csrc_reg;
        marker_next  = marker_reg;
        type_next    = type_reg;
        seq_next     = seq_reg;
        ts_next      = ts_reg;
        src_next     = src_reg;
        extlen_next  = extlen_reg;
        cnt_next     = cnt_reg;
        emit_payload = 1'b0;

        if (pos_reg >= MAX_POS) begin
            pos_next   = MAX_POS + 1'b1;
            phase_next = PH_DISCARD;
        end else begin
            pos_next = pos_reg + 1'b1;
            case (phase_reg)
                PH_FIXED: begin
                    if (pos_reg == '0) begin
                        version_next = data_byte[7:6];
                        padding_next = data_byte[5];
                        ext_next     = data_byte[4];
                        csrc_next    = data_byte[3:0];
                        marker_next  = 1'b0;
                        type_next    = '0;
                        seq_next     = '0;
                        ts_next      = '0;
                        src_next     = '0;
                        extlen_next  = '0;
                        if (data_byte[7:6] != rtphp_pkg::RTP_VERSION) begin
                            phase_next = PH_DISCARD;
                        end
                    end else if (pos_reg == POS_W'(1)) begin
                        marker_next = data_byte[7];
                        type_next   = data_byte[6:0];
                    end else if (pos_reg < POS_W'(4)) begin
                        seq_next = {seq_reg[7:0], data_byte};
                    end else if (pos_reg < POS_W'(8)) begin
                        ts_next = {ts_reg[23:0], data_byte};
                    end else begin
                        src_next = {src_reg[23:0], data_byte};
                        if (pos_reg >= POS_W'(11)) begin
                            if (csrc_reg != '0) begin
                                phase_next = PH_CSRC;
                                skip_next  = rtphp_pkg::SKIP_W'({csrc_reg, 2'b00});
                            end else if (ext_reg) begin
                                phase_next = PH_EXTHDR;
                                skip_next  = rtphp_pkg::SKIP_W'(4);
                            end else begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_CSRC: begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) begin
                        if (ext_reg) begin
                            phase_next = PH_EXTHDR;
                            skip_next  = rtphp_pkg::SKIP_W'(4);
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_EXTHDR: begin
                    // Last two bytes of the extension header give its word count
                    if (skip_reg <= rtphp_pkg::SKIP_W'(2)) begin
                        extlen_next = {extlen_reg[7:0], data_byte};
                    end
                    skip_next = skip_dec;
                    if (skip_dec == '0) begin
                        skip_next  = {extlen_next, 2'b00};
                        phase_next = (extlen_next != '0) ? PH_EXTBODY : PH_PAYLOAD;
                    end
                end
                PH_EXTBODY: begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    emit_payload = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Grade the packet on its final byte
    always_comb begin
        status = rtphp_pkg::ST_OK;
        pad    = '0;
        if (32'(pos_next) < 32'(rtphp_pkg::FIXED_HDR_BYTES)) begin
            status = rtphp_pkg::ST_SHORT;
        end else if (pos_next > MAX_POS) begin
            status = rtphp_pkg::ST_TOO_LONG;
        end else if (version_next != rtphp_pkg::RTP_VERSION) begin
            status = rtphp_pkg::ST_VERSION;
        end else if (phase_next == PH_CSRC) begin
            status = rtphp_pkg::ST_CSRC;
        end else if (phase_next == PH_EXTHDR || phase_next == PH_EXTBODY) begin
            status = rtphp_pkg::ST_EXTENSION;
        end else if (padding_next && cnt_next != '0) begin
            pad = data_byte;
            if (32'(data_byte) > 32'(cnt_next)) begin
                status = rtphp_pkg::ST_PADDING;
            end
        end
    end

    assign kept = cnt_next - POS_W'(pad);

    // Build the payload and summary transactions
    always_comb begin
        pay_res              = '0;
        pay_res.kind         = rtphp_pkg::KIND_PAYLOAD;
        pay_res.payload_byte = data_byte;

        sum_res              = '0;
        sum_res.kind         = rtphp_pkg::KIND_SUMMARY;
        sum_res.parse_status = status;
        sum_res.last_result  = 1'b1;
        if (status == rtphp_pkg::ST_OK) begin
            sum_res.marker_bit        = marker_next;
            sum_res.payload_kind      = type_next;
            sum_res.sequence_number   = seq_next;
            sum_res.media_timestamp   = ts_next;
            sum_res.source_id         = src_next;
            sum_res.contributor_count = csrc_next;
            sum_res.pad_count         = pad;
            if (32'(kept) > 32'(rtphp_pkg::LEN_MAX)) begin
                sum_res.payload_length = rtphp_pkg::LEN_W'(rtphp_pkg::LEN_MAX);
            end else begin
                sum_res.payload_length = rtphp_pkg::LEN_W'(32'(kept));
            end
        end
    end

    // Order the results: payload byte first, summary second
    always_comb begin
        push.count  = 2'd0;
        push.first  = pay_res;
        push.second = sum_res;
        if (in_accept) begin
            if (emit_payload) begin
                push.count = end_of_packet ? 2'd2 : 2'd1;
            end else if (end_of_packet) begin
                push.count = 2'd1;
                push.first = sum_res;
            end
        end
    end

    // Hold the parse state; return per-packet state to idle after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FIXED;
            pos_reg     <= '0;
            skip_reg    <= '0;
            version_reg <= '0;
            padding_reg <= 1'b0;
            ext_reg     <= 1'b0;
            csrc_reg    <= '0;
            marker_reg  <= 1'b0;
            type_reg    <= '0;
            seq_reg     <= '0;
            ts_reg      <= '0;
            src_reg     <= '0;
            extlen_reg  <= '0;
            cnt_reg     <= '0;
        end else if (in_accept) begin
            version_reg <= version_next;
            padding_reg <= padding_next;
            ext_reg     <= ext_next;
            csrc_reg    <= csrc_next;
            marker_reg  <= marker_next;
            type_reg    <= type_next;
            seq_reg     <= seq_next;
            ts_reg      <= ts_next;
            src_reg     <= src_next;
            extlen_reg  <= extlen_next;
            if (end_of_packet) begin
                phase_reg <= PH_FIXED;
                pos_reg   <= '0;
                skip_reg  <= '0;
                cnt_reg   <= '0;
            end else begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                skip_reg  <= skip_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

endmodule

/* design/rtphp_out_queue.sv */
`timescale 1ns / 1ps

module rtphp_out_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rtphp_pkg::push_t     push,
    input  logic                 pop,
    output logic                 has_room,
    output logic                 not_empty,
    output rtphp_pkg::result_t   head
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rtphp_pkg::result_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wptr_reg;
    logic [PTR_W-1:0]   rptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wptr_plus1;

    assign wptr_plus1 = wptr_reg + 1'b1;

    // Leave room for the two transactions that one final byte can produce
    assign has_room  = count_reg <= CNT_W'(DEPTH - 2);
    assign not_empty = count_reg != '0;
    assign head      = entry_reg[rptr_reg];

    // Store incoming results
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wptr_plus1] <= push.second;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_reg + PTR_W'(push.count);
            rptr_reg  <= rptr_reg + PTR_W'(pop);
            count_reg <= count_reg + CNT_W'(push.count) - CNT_W'(pop);
        end
    end

endmodule
